FILE: hdl/pdl_pkg.sv
`timescale 1ns / 1ps

package pdl_pkg;

  // defaults for the top level parameters
  localparam int unsigned CodeLengthDef = 6;
  localparam int unsigned QueueDepthDef = 2;

  // register and counter widths
  localparam int unsigned RunW   = 11;
  localparam int unsigned HoldW  = 11;
  localparam int unsigned AlarmW = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TickW  = 13;
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // register reset values
  localparam logic [RunW-1:0]   RunTicksRst   = 11'd469;
  localparam logic [HoldW-1:0]  HoldTicksRst  = 11'd94;
  localparam logic [AlarmW-1:0] AlarmTicksRst = 12'd1875;

  // link byte codes
  localparam logic [7:0] ByteReady    = 8'h01;
  localparam logic [7:0] ByteStore    = 8'h02;
  localparam logic [7:0] ByteCompare  = 8'h03;
  localparam logic [7:0] ByteMatch    = 8'h04;
  localparam logic [7:0] ByteOpen     = 8'h05;
  localparam logic [7:0] ByteOpened   = 8'h06;
  localparam logic [7:0] ByteClosed   = 8'h07;
  localparam logic [7:0] ByteAlarm    = 8'h08;
  localparam logic [7:0] ByteSafe     = 8'h09;
  localparam logic [7:0] ByteMismatch = 8'h00;
  localparam logic [7:0] ByteErased   = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RUN   = 2'd0,
    CFG_HOLD  = 2'd1,
    CFG_ALARM = 2'd2
  } cfg_reg_e;

  // item class decided by the front end
  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_OTHER,
    CLS_STORE,
    CLS_COMPARE,
    CLS_OPEN,
    CLS_ALARM,
    CLS_READY
  } item_class_e;

  typedef struct packed {
    item_class_e cls;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    RX_IDLE       = 2'd0,
    RX_STORE      = 2'd1,
    RX_COLLECT    = 2'd2,
    RX_WAIT_READY = 2'd3
  } rx_mode_e;

  typedef enum logic [1:0] {
    TMR_IDLE  = 2'd0,
    TMR_DOOR  = 2'd1,
    TMR_ALARM = 2'd2
  } timer_mode_e;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_CW   = 2'd1,
    MOTOR_CCW  = 2'd2
  } motor_e;

endpackage

FILE: hdl/password_door_lock_controller.sv
`timescale 1ns / 1ps

// channel | handshake                | fields
// --------+--------------------------+---------------------------------------------
// input   | in_valid_i, in_ready_o   | operation_i, rx_byte_i
// result  | out_valid_o, out_ready_i | tx_valid_o, tx_byte_o, motor_drive_o, buzzer_on_o
// config  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while the result port is ready; an item's result
// passes through the queue and then the result register before it can transfer.
// the per-item state update is done in the back end as each item is taken, so
// only a stalled result port limits throughput below one item per clock.
// reset clears the queue and the control state, loads the config registers with
// their defaults and sets the stored password to erased bytes; no clearing pass.
// a stalled result port fills the queue, after which in_ready_o drops.

module password_door_lock_controller #(
  parameter int unsigned CODE_LENGTH = pdl_pkg::CodeLengthDef,
  parameter int unsigned QUEUE_DEPTH = pdl_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         tx_valid_o,
  output logic [7:0]                   tx_byte_o,
  output logic [1:0]                   motor_drive_o,
  output logic                         buzzer_on_o,
  input  logic                         cfg_we_i,
  input  logic [pdl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pdl_pkg::CfgW-1:0]     cfg_data_i
);

  logic [pdl_pkg::RunW-1:0]   run_ticks_q;
  logic [pdl_pkg::HoldW-1:0]  hold_ticks_q;
  logic [pdl_pkg::AlarmW-1:0] alarm_ticks_q;

  pdl_pkg::queue_status_t q_status;
  pdl_pkg::item_t         push_item;
  pdl_pkg::item_t         pop_item;
  logic                   push;
  logic                   pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_ticks_q   <= pdl_pkg::RunTicksRst;
      hold_ticks_q  <= pdl_pkg::HoldTicksRst;
      alarm_ticks_q <= pdl_pkg::AlarmTicksRst;
    end else if (cfg_we_i) begin
      case (pdl_pkg::cfg_reg_e'(cfg_idx_i))
        pdl_pkg::CFG_RUN:   run_ticks_q   <= cfg_data_i[pdl_pkg::RunW-1:0];
        pdl_pkg::CFG_HOLD:  hold_ticks_q  <= cfg_data_i[pdl_pkg::HoldW-1:0];
        pdl_pkg::CFG_ALARM: alarm_ticks_q <= cfg_data_i[pdl_pkg::AlarmW-1:0];
        default: ;
      endcase
    end
  end

  // front end: classify and enqueue
  pdl_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decoupling queue
  pdl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // back end: execute and register the result
  pdl_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (!q_status.empty),
    .item_i        (pop_item),
    .item_pop_o    (pop),
    .run_ticks_i   (run_ticks_q),
    .hold_ticks_i  (hold_ticks_q),
    .alarm_ticks_i (alarm_ticks_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .motor_drive_o (motor_drive_o),
    .buzzer_on_o   (buzzer_on_o)
  );

  // queue never written when full
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue written while full");

  // queue never read when empty
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue read while empty");

  // a silent result carries a zero byte
  a_quiet_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> (tx_byte_o == 8'h00))
    else $error("tx byte set without tx valid");

  // motor code stays within stop, clockwise, anticlockwise
  a_motor_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_drive_o != 2'b11))
    else $error("illegal motor code");

endmodule

FILE: hdl/pdl_front.sv
`timescale 1ns / 1ps

module pdl_front (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [7:0]             rx_byte_i,
  input  pdl_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output pdl_pkg::item_t         push_item_o
);

  pdl_pkg::item_class_e cls;

  // classify an item: a tick when operation_i is set, else decode the command code of a link byte
  always_comb begin
    if (operation_i) begin
      cls = pdl_pkg::CLS_TICK;
    end else begin
      case (rx_byte_i)
        pdl_pkg::ByteStore:   cls = pdl_pkg::CLS_STORE;
        pdl_pkg::ByteCompare: cls = pdl_pkg::CLS_COMPARE;
        pdl_pkg::ByteOpen:    cls = pdl_pkg::CLS_OPEN;
        pdl_pkg::ByteAlarm:   cls = pdl_pkg::CLS_ALARM;
        pdl_pkg::ByteReady:   cls = pdl_pkg::CLS_READY;
        default:              cls = pdl_pkg::CLS_OTHER;
      endcase
    end
  end

  // transfer into the queue whenever there is room
  assign in_ready_o       = !q_status_i.full;
  assign push_o           = in_valid_i && in_ready_o;
  assign push_item_o.cls  = cls;
  assign push_item_o.data = rx_byte_i;

endmodule

FILE: hdl/pdl_queue.sv
`timescale 1ns / 1ps

module pdl_queue #(
  parameter int unsigned DEPTH = pdl_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pdl_pkg::item_t         push_item_i,
  input  logic                   pop_i,
  output pdl_pkg::item_t         pop_item_o,
  output pdl_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pdl_pkg::item_t slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o     = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

FILE: hdl/pdl_back.sv
`timescale 1ns / 1ps

module pdl_back #(
  parameter int unsigned CODE_LENGTH = pdl_pkg::CodeLengthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  pdl_pkg::item_t              item_i,
  output logic                        item_pop_o,
  input  logic [pdl_pkg::RunW-1:0]    run_ticks_i,
  input  logic [pdl_pkg::HoldW-1:0]   hold_ticks_i,
  input  logic [pdl_pkg::AlarmW-1:0]  alarm_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        tx_valid_o,
  output logic [7:0]                  tx_byte_o,
  output logic [1:0]                  motor_drive_o,
  output logic                        buzzer_on_o
);

  localparam int unsigned IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned TickW = pdl_pkg::TickW;

  logic [7:0] code_q [CODE_LENGTH];
  logic [7:0] code_d [CODE_LENGTH];

  pdl_pkg::rx_mode_e    rx_mode_q, rx_mode_d;
  pdl_pkg::timer_mode_e timer_q, timer_d;
  pdl_pkg::motor_e      motor_q, motor_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 mismatch_q, mismatch_d;
  logic [TickW-1:0]     tick_q, tick_d;
  logic                 buzzer_q, buzzer_d;

  logic             out_valid_q;
  logic             tx_valid_q;
  logic [7:0]       tx_byte_q;
  pdl_pkg::motor_e  motor_out_q;
  logic             buzzer_out_q;

  logic             take;
  logic             is_tick;
  logic             last_byte;
  logic [TickW-1:0] tick_inc;
  logic [TickW-1:0] thr_hold;
  logic [TickW-1:0] thr_close;
  logic             hit_open;
  logic             hit_hold;
  logic             hit_close;
  logic             hit_alarm;
  logic             tx_valid;
  logic [7:0]       tx_byte;

  // take an item when the result register is free or being drained
  assign take       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;
  assign is_tick    = (item_i.cls == pdl_pkg::CLS_TICK);
  assign last_byte  = (idx_q == IdxW'(CODE_LENGTH - 1));

  // saturating tick count and door sequence thresholds
  assign tick_inc  = (tick_q != pdl_pkg::TickMax) ? tick_q + 1'b1 : tick_q;
  assign thr_hold  = TickW'(run_ticks_i) + TickW'(hold_ticks_i);
  assign thr_close = thr_hold + TickW'(run_ticks_i);
  assign hit_open  = (tick_inc == TickW'(run_ticks_i));
  assign hit_hold  = (tick_inc == thr_hold);
  assign hit_close = (tick_inc == thr_close);
  assign hit_alarm = (tick_inc == TickW'(alarm_ticks_i));

  // next state
  always_comb begin
    code_d     = code_q;
    rx_mode_d  = rx_mode_q;
    timer_d    = timer_q;
    motor_d    = motor_q;
    idx_d      = idx_q;
    mismatch_d = mismatch_q;
    tick_d     = tick_q;
    buzzer_d   = buzzer_q;
    if (take) begin
      if (is_tick) begin
        case (timer_q)
          pdl_pkg::TMR_DOOR: begin
            tick_d = tick_inc;
            if (hit_open) begin
              motor_d = pdl_pkg::MOTOR_STOP;
            end
            if (hit_hold) begin
              motor_d = pdl_pkg::MOTOR_CCW;
            end
            if (hit_close) begin
              motor_d = pdl_pkg::MOTOR_STOP;
              tick_d  = '0;
              timer_d = pdl_pkg::TMR_IDLE;
            end
          end
          pdl_pkg::TMR_ALARM: begin
            tick_d = tick_inc;
            if (hit_alarm) begin
              buzzer_d = 1'b0;
              tick_d   = '0;
              timer_d  = pdl_pkg::TMR_IDLE;
            end
          end
          default: ;
        endcase
      end else begin
        case (rx_mode_q)
          pdl_pkg::RX_IDLE: begin
            case (item_i.cls)
              pdl_pkg::CLS_STORE: begin
                rx_mode_d  = pdl_pkg::RX_STORE;
                idx_d      = '0;
                mismatch_d = 1'b0;
              end
              pdl_pkg::CLS_COMPARE: begin
                rx_mode_d  = pdl_pkg::RX_COLLECT;
                idx_d      = '0;
                mismatch_d = 1'b0;
              end
              pdl_pkg::CLS_OPEN: begin
                tick_d  = '0;
                timer_d = pdl_pkg::TMR_DOOR;
                motor_d = pdl_pkg::MOTOR_CW;
              end
              pdl_pkg::CLS_ALARM: begin
                tick_d   = '0;
                timer_d  = pdl_pkg::TMR_ALARM;
                buzzer_d = 1'b1;
              end
              default: ;
            endcase
          end
          pdl_pkg::RX_STORE, pdl_pkg::RX_COLLECT: begin
            if (rx_mode_q == pdl_pkg::RX_STORE) begin
              code_d[idx_q] = item_i.data;
            end else if (code_q[idx_q] != item_i.data) begin
              mismatch_d = 1'b1;
            end
            if (last_byte) begin
              idx_d     = '0;
              rx_mode_d = (rx_mode_q == pdl_pkg::RX_STORE) ?
                          pdl_pkg::RX_IDLE : pdl_pkg::RX_WAIT_READY;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: begin
            if (item_i.cls == pdl_pkg::CLS_READY) begin
              rx_mode_d  = pdl_pkg::RX_IDLE;
              mismatch_d = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // link byte sent for the item
  always_comb begin
    tx_valid = 1'b0;
    tx_byte  = 8'h00;
    if (take) begin
      if (is_tick) begin
        case (timer_q)
          pdl_pkg::TMR_DOOR: begin
            if (hit_open) begin
              tx_valid = 1'b1;
              tx_byte  = pdl_pkg::ByteOpened;
            end
            if (hit_close) begin
              tx_valid = 1'b1;
              tx_byte  = pdl_pkg::ByteClosed;
            end
          end
          pdl_pkg::TMR_ALARM: begin
            if (hit_alarm) begin
              tx_valid = 1'b1;
              tx_byte  = pdl_pkg::ByteSafe;
            end
          end
          default: ;
        endcase
      end else begin
        case (rx_mode_q)
          pdl_pkg::RX_IDLE: begin
            if (item_i.cls == pdl_pkg::CLS_STORE || item_i.cls == pdl_pkg::CLS_COMPARE) begin
              tx_valid = 1'b1;
              tx_byte  = pdl_pkg::ByteReady;
            end
          end
          pdl_pkg::RX_STORE, pdl_pkg::RX_COLLECT: begin
            if (!last_byte) begin
              tx_valid = 1'b1;
              tx_byte  = pdl_pkg::ByteReady;
            end
          end
          default: begin
            if (item_i.cls == pdl_pkg::CLS_READY) begin
              tx_valid = 1'b1;
              tx_byte  = mismatch_q ? pdl_pkg::ByteMismatch : pdl_pkg::ByteMatch;
            end
          end
        endcase
      end
    end
  end

  // state registers, the password store resets to erased
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        code_q[i] <= pdl_pkg::ByteErased;
      end
      rx_mode_q  <= pdl_pkg::RX_IDLE;
      timer_q    <= pdl_pkg::TMR_IDLE;
      motor_q    <= pdl_pkg::MOTOR_STOP;
      idx_q      <= '0;
      mismatch_q <= 1'b0;
      tick_q     <= '0;
      buzzer_q   <= 1'b0;
    end else begin
      code_q     <= code_d;
      rx_mode_q  <= rx_mode_d;
      timer_q    <= timer_d;
      motor_q    <= motor_d;
      idx_q      <= idx_d;
      mismatch_q <= mismatch_d;
      tick_q     <= tick_d;
      buzzer_q   <= buzzer_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      tx_valid_q   <= tx_valid;
      tx_byte_q    <= tx_byte;
      motor_out_q  <= motor_d;
      buzzer_out_q <= buzzer_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign motor_drive_o = motor_out_q;
  assign buzzer_on_o   = buzzer_out_q;

endmodule
